[rtl/core/ssp_pkg.sv]
// shared types for the soft-sphere pair force pipeline
// no dependencies; used by ssp_div, ssp_mulq and soft_sphere_pair_force
`default_nettype none

package ssp_pkg;

  // wide datapath words
  localparam int WordW  = 64;
  localparam int DispW  = 25;
  localparam int R2W    = 50;

  // config register indexes
  localparam logic RegBox = 1'b0;
  localparam logic RegCut = 1'b1;

  // per-pair data that rides along the arithmetic stages
  typedef struct packed {
    logic [2:0][DispW-1:0] d;
    logic [R2W-1:0]        r2;
    logic                  in_cut;
    logic                  coinc;
    logic                  clip;
  } ssp_side_t;

  // side data that also carries w4 into the w12 product
  typedef struct packed {
    ssp_side_t        base;
    logic [WordW-1:0] w4;
  } ssp_wside_t;

  // side data through the force divider
  typedef struct packed {
    ssp_side_t   base;
    logic [31:0] energy;
    logic        gclip;
  } ssp_gside_t;

endpackage

`default_nettype wire

[rtl/core/soft_sphere_pair_force.sv]
// soft-sphere r^-12 pair force with minimum-image wrap, top level
// depends on ssp_pkg, ssp_div and ssp_mulq
`default_nettype none

// Takes one particle pair per cycle while in_tready is high and returns one
// result per pair, in order. The pipeline is made of the two radix-2
// divider pipelines (64 stages each, for (size/r)^2 and for 12*w12/r2),
// plus three two-stage 64x64 product units and six short stages for the
// wrap, squares, sums and force products. The whole pipeline advances
// together: when the output register holds a result that is not taken,
// in_tready drops and every stage holds. Configuration must be written
// while no pair is in flight.
module soft_sphere_pair_force import ssp_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // first_radius, second_radius, zero pad
  input  wire logic [183:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // force_x, force_y, force_z, pair_energy, in_cutoff, saturated,
  // coincident, zero pad
  output logic [135:0]      out_tdata
);

  localparam int   ShE    = 32 - FRACTION_BITS;
  localparam int   ShG    = 2 * FRACTION_BITS + 2;

  logic        en;
  logic [23:0] box_r;
  logic [31:0] cut_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= 24'd1269101;
      cut_r <= 32'd589824;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegBox:  box_r <= cfg_wdata[23:0];
        RegCut:  cut_r <= cfg_wdata;
        default: box_r <= box_r;
      endcase
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  function automatic logic [DispW-1:0] wrap_d(input logic [23:0] fst,
                                              input logic [23:0] sec,
                                              input logic [23:0] len);
    logic signed [26:0] raw, two, l;
    raw = $signed({3'b000, sec}) - $signed({3'b000, fst});
    two = raw <<< 1;
    l   = $signed({3'b000, len});
    if (two > l) begin
      raw = raw - l;
    end else if (two < -l) begin
      raw = raw + l;
    end
    return raw[DispW-1:0];
  endfunction

  // stage 1: displacement with nearest image, radius sum
  logic                  s1_vld_r;
  logic [2:0][DispW-1:0] s1_d_r;
  logic [18:0]           s1_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_d_r[k] <= wrap_d(in_tdata[24*k +: 24], in_tdata[24*(k+3) +: 24], box_r);
      end
      s1_s_r <= {1'b0, in_tdata[161:144]} + {1'b0, in_tdata[179:162]};
    end
  end

  // stage 2: squares
  logic                  s2_vld_r;
  logic [2:0][DispW-1:0] s2_d_r;
  logic [2:0][47:0]      s2_sq_r;
  logic [37:0]           s2_ss_r;
  logic signed [49:0]    sq_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_c[k] = $signed(s1_d_r[k]) * $signed(s1_d_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d_r <= s1_d_r;
      for (int k = 0; k < 3; k++) begin
        s2_sq_r[k] <= sq_c[k][47:0];
      end
      s2_ss_r <= s1_s_r * s1_s_r;
    end
  end

  // stage 3: r2, cutoff test, w2 divider operands
  logic           s3_vld_r;
  ssp_side_t      s3_side_r;
  logic [51:0]    s3_rem_r;
  logic [63:0]    s3_num_r;
  logic [51:0]    s3_den_r;
  logic [R2W-1:0] r2_c;
  logic [63:0]    cut64_c;

  assign r2_c    = {2'b00, s2_sq_r[0]} + {2'b00, s2_sq_r[1]} + {2'b00, s2_sq_r[2]};
  assign cut64_c = {32'd0, cut_r} << FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r.d      <= s2_d_r;
      s3_side_r.r2     <= r2_c;
      s3_side_r.in_cut <= {14'd0, r2_c} < cut64_c;
      s3_side_r.coinc  <= r2_c == '0;
      s3_side_r.clip   <= {46'd0, s2_ss_r[37:32]} >= {r2_c, 2'b00};
      s3_rem_r         <= {46'd0, s2_ss_r[37:32]};
      s3_num_r         <= {s2_ss_r[31:0], 32'd0};
      s3_den_r         <= {r2_c, 2'b00};
    end
  end

  // w2 = size^2 / r2 in Q32.32
  logic       d1_vld;
  logic [63:0] d1_q;
  ssp_side_t  d1_side;

  ssp_div #(.DW(52), .QW(64), .PW($bits(ssp_side_t))) u_div_w2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s3_vld_r), .in_rem(s3_rem_r), .in_num(s3_num_r), .in_den(s3_den_r),
    .in_side(s3_side_r),
    .out_valid(d1_vld), .out_quo(d1_q), .out_side(d1_side)
  );

  logic [63:0] w2_c;
  assign w2_c = d1_side.clip ? '1 : d1_q;

  // w4, w8, w12
  logic        m4_vld, m4_clip;
  logic [63:0] m4_q;
  ssp_side_t   m4_side;
  ssp_wside_t  m8_in_side;

  ssp_mulq #(.PW($bits(ssp_side_t))) u_mul_w4 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(d1_vld), .in_a(w2_c), .in_b(w2_c), .in_side(d1_side),
    .out_valid(m4_vld), .out_q(m4_q), .out_clip(m4_clip), .out_side(m4_side)
  );

  always_comb begin
    m8_in_side           = '{base: m4_side, w4: m4_q};
    m8_in_side.base.clip = m4_side.clip | m4_clip;
  end

  logic        m8_vld, m8_clip;
  logic [63:0] m8_q;
  ssp_wside_t  m8_side;
  ssp_side_t   m12_in_side;

  ssp_mulq #(.PW($bits(ssp_wside_t))) u_mul_w8 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(m4_vld), .in_a(m4_q), .in_b(m4_q), .in_side(m8_in_side),
    .out_valid(m8_vld), .out_q(m8_q), .out_clip(m8_clip), .out_side(m8_side)
  );

  always_comb begin
    m12_in_side      = m8_side.base;
    m12_in_side.clip = m8_side.base.clip | m8_clip;
  end

  logic        m12_vld, m12_clip;
  logic [63:0] m12_q;
  ssp_side_t   m12_side;

  ssp_mulq #(.PW($bits(ssp_side_t))) u_mul_w12 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(m8_vld), .in_a(m8_q), .in_b(m8_side.w4), .in_side(m12_in_side),
    .out_valid(m12_vld), .out_q(m12_q), .out_clip(m12_clip), .out_side(m12_side)
  );

  // stage e: energy and operands of 12*w12/r2
  logic         e_vld_r;
  ssp_gside_t   e_side_r;
  ssp_gside_t   e_side_nxt;
  logic [49:0]  e_rem_r;
  logic [63:0]  e_num_r;
  logic [63:0]  e64_c;
  logic         eclip_c;
  logic [65:0]  w3_c;
  logic [127:0] n128_c;
  logic         gclip_c;

  always_comb begin
    e64_c   = m12_q >> ShE;
    eclip_c = |e64_c[63:32];
    w3_c    = {2'b00, m12_q} + {1'b0, m12_q, 1'b0};
    n128_c  = {62'd0, w3_c} << ShG;
    gclip_c = n128_c[127:64] >= {14'd0, m12_side.r2};
    e_side_nxt           = '{base: m12_side, energy: '0, gclip: gclip_c};
    e_side_nxt.base.clip = m12_side.clip | m12_clip | eclip_c | gclip_c;
    e_side_nxt.energy    = eclip_c ? '1 : e64_c[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= m12_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side_r <= e_side_nxt;
      e_rem_r  <= n128_c[113:64];
      e_num_r  <= n128_c[63:0];
    end
  end

  // g = 12 * w12 / r2 in Q32.32
  logic        d2_vld;
  logic [63:0] d2_q;
  ssp_gside_t  d2_side;

  ssp_div #(.DW(R2W), .QW(64), .PW($bits(ssp_gside_t))) u_div_g (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(e_vld_r), .in_rem(e_rem_r), .in_num(e_num_r), .in_den(e_side_r.base.r2),
    .in_side(e_side_r),
    .out_valid(d2_vld), .out_quo(d2_q), .out_side(d2_side)
  );

  logic [63:0] g_c;
  assign g_c = d2_side.gclip ? '1 : d2_q;

  // stage fa: half products of g and |d|
  logic              fa_vld_r;
  ssp_gside_t        fa_side_r;
  logic [2:0][56:0]  fa_pl_r, fa_ph_r;
  logic [DispW-1:0]  ad_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ad_c[k] = d2_side.base.d[k][DispW-1] ? (~d2_side.base.d[k] + 1'b1)
                                           : d2_side.base.d[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_vld_r <= 1'b0;
    end else if (en) begin
      fa_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fa_side_r <= d2_side;
      for (int k = 0; k < 3; k++) begin
        fa_pl_r[k] <= g_c[31:0]  * ad_c[k];
        fa_ph_r[k] <= g_c[63:32] * ad_c[k];
      end
    end
  end

  // stage fb: force magnitude, sign, saturation and output masking
  logic              out_vld_r;
  logic [135:0]      out_data_r;
  logic [135:0]      out_data_nxt;
  logic [2:0][31:0]  f_c;
  logic              fclip_c;
  logic [88:0]       prod_c;
  logic [56:0]       mag_c;
  logic              pos_c;

  always_comb begin
    fclip_c = 1'b0;
    for (int k = 0; k < 3; k++) begin
      prod_c = {fa_ph_r[k], 32'd0} + {32'd0, fa_pl_r[k]};
      mag_c  = prod_c[88:32];
      pos_c  = !fa_side_r.base.d[k][DispW-1] && (fa_side_r.base.d[k] != '0);
      if (pos_c) begin
        if (mag_c > 57'h80000000) begin
          f_c[k]  = 32'h80000000;
          fclip_c = 1'b1;
        end else begin
          f_c[k] = 32'd0 - mag_c[31:0];
        end
      end else begin
        if (mag_c > 57'h7FFFFFFF) begin
          f_c[k]  = 32'h7FFFFFFF;
          fclip_c = 1'b1;
        end else begin
          f_c[k] = mag_c[31:0];
        end
      end
    end
  end

  // result word with masking for coincident and outside pairs
  always_comb begin
    out_data_nxt = '0;
    if (fa_side_r.base.coinc) begin
      out_data_nxt[130] = 1'b1;
    end else if (fa_side_r.base.in_cut) begin
      out_data_nxt[95:0]   = f_c;
      out_data_nxt[127:96] = fa_side_r.energy;
      out_data_nxt[128]    = 1'b1;
      out_data_nxt[129]    = fa_side_r.base.clip | fclip_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= fa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // a coincident pair carries no other result
  a_coinc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[130] |-> out_tdata[129:0] == '0)
    else $error("coincident result carries nonzero fields");

  // outside the cutoff only zeros leave
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[128] |-> out_tdata[127:0] == '0 && !out_tdata[129])
    else $error("result outside cutoff is not zero");

  // pipeline holds while a result waits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && !$past(in_tready))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

[rtl/core/ssp_div.sv]
// pipelined restoring divider, one quotient bit per register stage
// depends on ssp_pkg
`default_nettype none

module ssp_div import ssp_pkg::*; #(
  parameter int DW = 52,
  parameter int QW = 64,
  parameter int PW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_rem,
  input  wire logic [QW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [PW-1:0] in_side,
  output logic               out_valid,
  output logic [QW-1:0]      out_quo,
  output logic [PW-1:0]      out_side
);

  logic [QW-1:0] vld_r;
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] num_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [PW-1:0] side_r [QW];
  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] num_nxt [QW];

  // one shift-and-subtract step per stage; quotient bits shift in at the bottom
  always_comb begin
    logic [DW-1:0] src_rem;
    logic [QW-1:0] src_num;
    logic [DW-1:0] src_den;
    logic [DW:0]   cand;
    logic [DW:0]   diff;
    for (int i = 0; i < QW; i++) begin
      src_rem = (i == 0) ? in_rem : rem_r[(i == 0) ? 0 : i-1];
      src_num = (i == 0) ? in_num : num_r[(i == 0) ? 0 : i-1];
      src_den = (i == 0) ? in_den : den_r[(i == 0) ? 0 : i-1];
      cand = {src_rem, src_num[QW-1]};
      diff = cand - {1'b0, src_den};
      if (cand >= {1'b0, src_den}) begin
        rem_nxt[i] = diff[DW-1:0];
        num_nxt[i] = {src_num[QW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = cand[DW-1:0];
        num_nxt[i] = {src_num[QW-2:0], 1'b0};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], in_valid};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        rem_r[i] <= rem_nxt[i];
        num_r[i] <= num_nxt[i];
        den_r[i]  <= (i == 0) ? in_den  : den_r[(i == 0) ? 0 : i-1];
        side_r[i] <= (i == 0) ? in_side : side_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = num_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

`default_nettype wire

[rtl/core/ssp_mulq.sv]
// two-stage 64x64 product scaled by 2^-32, clipped to 64 bits
// depends on ssp_pkg
`default_nettype none

module ssp_mulq import ssp_pkg::*; #(
  parameter int PW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [WordW-1:0] in_a,
  input  wire logic [WordW-1:0] in_b,
  input  wire logic [PW-1:0]    in_side,
  output logic                  out_valid,
  output logic [WordW-1:0]      out_q,
  output logic                  out_clip,
  output logic [PW-1:0]         out_side
);

  logic             p_vld_r;
  logic [63:0]      p00_r, p01_r, p10_r, p11_r;
  logic [PW-1:0]    p_side_r;
  logic             q_vld_r;
  logic [WordW-1:0] q_r;
  logic             clip_r;
  logic [PW-1:0]    q_side_r;
  logic [127:0]     prod;

  // combine partial products
  assign prod = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
              + {p11_r, 64'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      q_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= in_valid;
      q_vld_r <= p_vld_r;
    end
  end

  // partial products, then sum and clip
  always_ff @(posedge clk) begin
    if (en) begin
      p00_r    <= in_a[31:0]  * in_b[31:0];
      p01_r    <= in_a[31:0]  * in_b[63:32];
      p10_r    <= in_a[63:32] * in_b[31:0];
      p11_r    <= in_a[63:32] * in_b[63:32];
      p_side_r <= in_side;
      clip_r   <= |prod[127:96];
      q_r      <= (|prod[127:96]) ? '1 : prod[95:32];
      q_side_r <= p_side_r;
    end
  end

  assign out_valid = q_vld_r;
  assign out_q     = q_r;
  assign out_clip  = clip_r;
  assign out_side  = q_side_r;

endmodule

`default_nettype wire
